@@ sv/smsd_pkg.sv @@
// smsd_pkg: widths, step counts and controller/datapath handshake structs
// for the sample mean / standard deviation block.
// No dependencies; every other file of the block but smsd_ram imports it.
package smsd_pkg;

  localparam int unsigned MAX_SAMPLES = 256;
  localparam int unsigned SAMPLE_W    = 24;

  localparam int unsigned CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned ADDR_W = $clog2(MAX_SAMPLES);
  localparam int unsigned SUM_W  = SAMPLE_W + ADDR_W + 1;
  localparam int unsigned SQ_W   = 2 * SAMPLE_W;
  localparam int unsigned ACC_W  = SQ_W + ADDR_W;
  localparam int unsigned DIV_W  = (ACC_W > SUM_W) ? ACC_W : SUM_W;
  localparam int unsigned RAD_W  = ((DIV_W + 1) / 2) * 2;
  localparam int unsigned ROOT_W = RAD_W / 2;
  localparam int unsigned SREM_W = ROOT_W + 3;
  localparam int unsigned STEP_W = $clog2(DIV_W + 1);

  typedef struct packed {
    logic load;
    logic div_ld_mean;
    logic div_ld_var;
    logic div_step;
    logic mean_cap;
    logic walk_start;
    logic walk_step;
    logic sqrt_ld;
    logic sqrt_step;
    logic res_wr;
  } smsd_cmd_t;

  typedef struct packed {
    logic few;
    logic walk_done;
    logic out_busy;
  } smsd_sts_t;

endpackage

@@ sv/smsd_in_if.sv @@
// smsd_in_if: input channel carrying one sample and its last flag.
// Depends on smsd_pkg for the sample width.
interface smsd_in_if;
  import smsd_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic                last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

@@ sv/smsd_out_if.sv @@
// smsd_out_if: result channel with count, mean, deviation and too_few flag.
// Depends on smsd_pkg for field widths.
interface smsd_out_if;
  import smsd_pkg::*;

  logic                valid;
  logic                ready;
  logic [CNT_W-1:0]    sample_count;
  logic [SAMPLE_W-1:0] mean_value;
  logic [SAMPLE_W-1:0] std_dev;
  logic                too_few;

  modport source (output valid, output sample_count, output mean_value,
                  output std_dev, output too_few, input ready);
  modport sink   (input valid, input sample_count, input mean_value,
                  input std_dev, input too_few, output ready);
endinterface

@@ sv/smsd_ram.sv @@
// smsd_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies.
module smsd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/smsd_ctrl.sv @@
// smsd_ctrl: sequencer for load, mean divide, buffer walk, variance divide,
// square root and result write. Depends on smsd_pkg.
module smsd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_last_i,
  output logic                in_ready_o,
  input  smsd_pkg::smsd_sts_t sts_i,
  output smsd_pkg::smsd_cmd_t cmd_o
);
  import smsd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MEAN_LD, S_MEAN, S_MEAN_CAP, S_WALK,
    S_VAR_LD, S_VAR, S_SQRT_LD, S_SQRT, S_DONE
  } state_e;

  state_e            state_q;
  logic [STEP_W-1:0] cnt_q;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE:     cmd_o.load        = in_valid_i;
      S_MEAN_LD:  cmd_o.div_ld_mean = 1'b1;
      S_MEAN:     cmd_o.div_step    = 1'b1;
      S_MEAN_CAP: begin
        cmd_o.mean_cap   = 1'b1;
        cmd_o.walk_start = !sts_i.few;
      end
      S_WALK:     cmd_o.walk_step   = 1'b1;
      S_VAR_LD:   cmd_o.div_ld_var  = 1'b1;
      S_VAR:      cmd_o.div_step    = 1'b1;
      S_SQRT_LD:  cmd_o.sqrt_ld     = 1'b1;
      S_SQRT:     cmd_o.sqrt_step   = 1'b1;
      S_DONE:     cmd_o.res_wr      = !sts_i.out_busy;
      default:    cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i && in_last_i) begin
            state_q <= S_MEAN_LD;
          end
        end
        S_MEAN_LD: begin
          state_q <= S_MEAN;
          cnt_q   <= STEP_W'(DIV_W - 1);
        end
        S_MEAN: begin
          if (cnt_q == '0) begin
            state_q <= S_MEAN_CAP;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        S_MEAN_CAP: state_q <= sts_i.few ? S_DONE : S_WALK;
        S_WALK: begin
          if (sts_i.walk_done) begin
            state_q <= S_VAR_LD;
          end
        end
        S_VAR_LD: begin
          state_q <= S_VAR;
          cnt_q   <= STEP_W'(DIV_W - 1);
        end
        S_VAR: begin
          if (cnt_q == '0) begin
            state_q <= S_SQRT_LD;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        S_SQRT_LD: begin
          state_q <= S_SQRT;
          cnt_q   <= STEP_W'(ROOT_W - 1);
        end
        S_SQRT: begin
          if (cnt_q == '0) begin
            state_q <= S_DONE;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        S_DONE: begin
          if (!sts_i.out_busy) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_res_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_wr |-> !sts_i.out_busy)
    else $error("result written while output slot occupied");

  a_one_load_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.div_ld_mean, cmd_o.div_ld_var, cmd_o.sqrt_ld,
              cmd_o.res_wr}))
    else $error("conflicting datapath load commands");

  a_walk_needs_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.walk_step |-> !sts_i.few)
    else $error("buffer walk with fewer than two samples");

endmodule

@@ sv/smsd_dp.sv @@
// smsd_dp: sample buffer, running sum, squared-deviation walk, shared
// radix-2 divider, bit-pair square root and result register.
// Depends on smsd_pkg and smsd_ram.
module smsd_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  smsd_pkg::smsd_cmd_t           cmd_i,
  output smsd_pkg::smsd_sts_t           sts_o,
  input  logic [smsd_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [smsd_pkg::CNT_W-1:0]    sample_count_o,
  output logic [smsd_pkg::SAMPLE_W-1:0] mean_value_o,
  output logic [smsd_pkg::SAMPLE_W-1:0] std_dev_o,
  output logic                          too_few_o
);
  import smsd_pkg::*;

  // control state
  logic [CNT_W-1:0]    fill_q;
  logic [SUM_W-1:0]    sum_q;
  logic [CNT_W-1:0]    idx_q;
  logic                rd_vld_q;
  logic                sq_vld_q;
  logic                out_vld_q;
  // payload
  logic [SAMPLE_W-1:0] mean_q;
  logic [SQ_W-1:0]     sq_q;
  logic [ACC_W-1:0]    acc_q;
  logic [CNT_W-1:0]    rem_q;
  logic [CNT_W-1:0]    dvs_q;
  logic [DIV_W-1:0]    quo_q;
  logic [RAD_W-1:0]    rad_q;
  logic [SREM_W-1:0]   srem_q;
  logic [ROOT_W-1:0]   root_q;
  logic [CNT_W-1:0]    cnt_out_q;
  logic [SAMPLE_W-1:0] mean_out_q;
  logic [SAMPLE_W-1:0] sd_out_q;
  logic                few_out_q;

  logic                not_full;
  logic                wr_en;
  logic                rd_en;
  logic                few;
  logic [SAMPLE_W-1:0] rdata;
  logic [SUM_W-1:0]    sample_ext;
  logic [SUM_W-1:0]    sum_abs;
  logic [SAMPLE_W-1:0] quo_lo;
  logic [SAMPLE_W:0]   diff;
  logic [SAMPLE_W:0]   diff_abs;
  logic [SAMPLE_W-1:0] mag;
  logic [CNT_W:0]      div_sh;
  logic                div_ge;
  logic [CNT_W:0]      div_sub;
  logic [SREM_W-1:0]   sq_sh;
  logic [SREM_W-1:0]   sq_trial;
  logic                sq_ge;
  logic [SAMPLE_W-1:0] sd_sat;

  assign not_full   = fill_q < CNT_W'(MAX_SAMPLES);
  assign wr_en      = cmd_i.load && not_full;
  assign rd_en      = cmd_i.walk_step && (idx_q < fill_q);
  assign few        = fill_q < CNT_W'(2);
  assign sample_ext = {{(SUM_W - SAMPLE_W){sample_i[SAMPLE_W-1]}}, sample_i};
  assign sum_abs    = sum_q[SUM_W-1] ? (~sum_q + 1'b1) : sum_q;
  assign quo_lo     = quo_q[SAMPLE_W-1:0];

  smsd_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_SAMPLES)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (fill_q[ADDR_W-1:0]),
    .wdata_i (sample_i),
    .re_i    (rd_en),
    .raddr_i (idx_q[ADDR_W-1:0]),
    .rdata_o (rdata)
  );

  // deviation magnitude fits SAMPLE_W bits for in-range mean and sample
  assign diff     = {rdata[SAMPLE_W-1], rdata} - {mean_q[SAMPLE_W-1], mean_q};
  assign diff_abs = diff[SAMPLE_W] ? (~diff + 1'b1) : diff;
  assign mag      = diff_abs[SAMPLE_W-1:0];

  // restoring divide, one quotient bit per step
  assign div_sh  = {rem_q, quo_q[DIV_W-1]};
  assign div_ge  = div_sh >= {1'b0, dvs_q};
  assign div_sub = div_sh - {1'b0, dvs_q};

  // floor square root, two radicand bits per step
  assign sq_sh    = {srem_q[SREM_W-3:0], rad_q[RAD_W-1 -: 2]};
  assign sq_trial = SREM_W'({root_q, 2'b01});
  assign sq_ge    = sq_sh >= sq_trial;

  assign sd_sat = (|root_q[ROOT_W-1:SAMPLE_W]) ? '1 : root_q[SAMPLE_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      sum_q     <= '0;
      idx_q     <= '0;
      rd_vld_q  <= 1'b0;
      sq_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        fill_q <= fill_q + 1'b1;
        sum_q  <= sum_q + sample_ext;
      end
      if (cmd_i.walk_start) begin
        idx_q <= '0;
      end else if (rd_en) begin
        idx_q <= idx_q + 1'b1;
      end
      rd_vld_q <= rd_en;
      sq_vld_q <= rd_vld_q;
      if (cmd_i.res_wr) begin
        out_vld_q <= 1'b1;
        fill_q    <= '0;
        sum_q     <= '0;
      end else if (out_vld_q && out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_ld_mean) begin
      quo_q <= DIV_W'(sum_abs);
      dvs_q <= fill_q;
      rem_q <= '0;
    end else if (cmd_i.div_ld_var) begin
      quo_q <= DIV_W'(acc_q);
      dvs_q <= fill_q - 1'b1;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[DIV_W-2:0], div_ge};
      rem_q <= div_ge ? div_sub[CNT_W-1:0] : div_sh[CNT_W-1:0];
    end

    if (cmd_i.mean_cap) begin
      if (fill_q == '0) begin
        mean_q <= '0;
      end else begin
        mean_q <= sum_q[SUM_W-1] ? (~quo_lo + 1'b1) : quo_lo;
      end
    end

    if (rd_vld_q) begin
      sq_q <= mag * mag;
    end
    if (cmd_i.walk_start) begin
      acc_q <= '0;
    end else if (sq_vld_q) begin
      acc_q <= acc_q + ACC_W'(sq_q);
    end

    if (cmd_i.sqrt_ld) begin
      rad_q  <= RAD_W'(quo_q);
      srem_q <= '0;
      root_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
      srem_q <= sq_ge ? (sq_sh - sq_trial) : sq_sh;
      root_q <= {root_q[ROOT_W-2:0], sq_ge};
    end

    if (cmd_i.res_wr) begin
      cnt_out_q  <= fill_q;
      mean_out_q <= mean_q;
      sd_out_q   <= few ? '0 : sd_sat;
      few_out_q  <= few;
    end
  end

  assign sts_o.few       = few;
  assign sts_o.walk_done = (idx_q == fill_q) && !rd_vld_q && !sq_vld_q;
  assign sts_o.out_busy  = out_vld_q;

  assign out_valid_o    = out_vld_q;
  assign sample_count_o = cnt_out_q;
  assign mean_value_o   = mean_out_q;
  assign std_dev_o      = sd_out_q;
  assign too_few_o      = few_out_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(MAX_SAMPLES))
    else $error("fill count beyond buffer depth");

  a_set_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.res_wr |=> (fill_q == '0) && (sum_q == '0))
    else $error("set not emptied after result");

  a_few_zero_sd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && few_out_q) |-> (sd_out_q == '0))
    else $error("nonzero deviation with too_few");

endmodule

@@ sv/sample_mean_stdev.sv @@
// sample_mean_stdev: top level, joins the sequencer and the datapath.
// Depends on smsd_pkg, smsd_in_if, smsd_out_if, smsd_ctrl, smsd_dp.
//
// Usage:
//   in_i carries one signed Q15.8 sample per item plus a last flag. Samples
//   are buffered (up to 256; later ones are dropped) and summed. Items
//   without last are taken one per cycle while the block is idle.
//   The item with last closes the set. out_o then gives one item: count,
//   mean (truncated toward zero), floor sample standard deviation, and
//   too_few when fewer than two samples were held (deviation zero).
//   After the closing item the block runs two passes of the 56-step shared
//   divider, a walk over the buffer RAM read port and a 28-step square root
//   for n >= 2 samples, and only the mean divide otherwise. in_i.ready is
//   low during that time.
//   The result sits in an output register; new samples for the next set are
//   accepted while it waits. If out_o.ready stays low, a second closing item
//   finishes its computation and then waits until the first result is taken.
//   Reset empties the set and drops any pending result; no clearing pass.
module sample_mean_stdev (
  input logic        clk_i,
  input logic        rst_ni,
  smsd_in_if.sink    in_i,
  smsd_out_if.source out_o
);
  import smsd_pkg::*;

  smsd_cmd_t cmd;
  smsd_sts_t sts;

  smsd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_last_i  (in_i.last),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  smsd_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .sample_i       (in_i.sample),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .sample_count_o (out_o.sample_count),
    .mean_value_o   (out_o.mean_value),
    .std_dev_o      (out_o.std_dev),
    .too_few_o      (out_o.too_few)
  );

endmodule
